[hdl/ordered_session_table_with_eviction_unit_assert.svh]
// assertion macros for the session table
`ifndef ORDERED_SESSION_TABLE_WITH_EVICTION_UNIT_ASSERT_SVH
`define ORDERED_SESSION_TABLE_WITH_EVICTION_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define OST_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define OST_ASSERT_NORST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define OST_ASSERT(lbl, prop, msg)
`define OST_ASSERT_NORST(lbl, prop, msg)
`endif
`endif

[hdl/ostab_pkg.sv]
// ----------------------------------------------------------------------------
// ostab_pkg
// shared types and constants of the ordered session table
// ----------------------------------------------------------------------------
`default_nettype none
package ostab_pkg;
  localparam int unsigned TableDepth = 16;
  localparam int unsigned KeyWidth   = 64;
  localparam int unsigned IdxW       = $clog2(TableDepth);
  localparam int unsigned CntW       = $clog2(TableDepth + 1);
  // entry: handle, user, uid, uri, evictable
  localparam int unsigned EntryW     = 2 * KeyWidth + 64 + 1;

  localparam logic [1:0] ActCreate   = 2'd0;
  localparam logic [1:0] ActQuery    = 2'd1;
  localparam logic [1:0] ActDelete   = 2'd2;
  localparam logic [1:0] ActCriteria = 2'd3;

  localparam logic [1:0] StOk       = 2'd0;
  localparam logic [1:0] StLimit    = 2'd1;
  localparam logic [1:0] StNotFound = 2'd2;

  localparam logic [1:0] ModeUser    = 2'd0;
  localparam logic [1:0] ModeCaller  = 2'd1;
  localparam logic [1:0] ModeUri     = 2'd2;

  typedef struct packed {
    logic [KeyWidth-1:0] handle;
    logic [31:0]         user;
    logic [31:0]         uid;
    logic [KeyWidth-1:0] uri;
    logic                evict;
  } entry_t;

  typedef struct packed {
    logic [1:0]          status;
    logic [3:0]          found_slot;
    logic                abort_request;
    logic [63:0]         abort_key;
    logic [4:0]          live_count;
    logic                last;
  } result_t;
endpackage
`default_nettype wire

[hdl/ostab_ram.sv]
// ----------------------------------------------------------------------------
// ostab_ram
// generic single-port-write, single-read ram with registered read
// ----------------------------------------------------------------------------
`default_nettype none
module ostab_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

[hdl/ostab_ctrl.sv]
// ----------------------------------------------------------------------------
// ostab_ctrl
// sequencer: scans the entry ram, removes with in-place compaction, appends
// ----------------------------------------------------------------------------
`default_nettype none
`include "ordered_session_table_with_eviction_unit_assert.svh"
module ostab_ctrl
  import ostab_pkg::*;
(
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic [4:0]    limit_i,
  input  wire logic          start_i,
  input  wire logic [1:0]    action_i,
  input  wire entry_t        cmd_i,
  input  wire logic [1:0]    mode_i,
  output logic               busy_o,
  output logic               res_valid_o,
  input  wire logic          res_ready_i,
  output result_t            res_o
);
  localparam logic [1:0] SIdle = 2'd0;
  localparam logic [1:0] SScan = 2'd1;
  localparam logic [1:0] SEnd  = 2'd2;

  logic [1:0]      state_q, state_d;
  logic [1:0]      act_q;
  logic [1:0]      mode_q;
  entry_t          cmd_q;
  logic [CntW-1:0] total_q, total_d;
  logic [CntW-1:0] rd_q, rd_d;     // read pointer
  logic [CntW-1:0] wr_q, wr_d;     // compaction write pointer
  logic [CntW-1:0] rm_q, rm_d;     // criteria removals so far
  logic [IdxW-1:0] cur_q, cur_d;   // index of the entry in rdata
  logic            rvld_q, rvld_d; // rdata holds entry cur_q
  logic            hits_q, hits_d; // removal made, query hit or criteria result pending
  logic            full_q, full_d; // create found the table at the limit
  logic [IdxW-1:0] slot_q, slot_d;
  logic [63:0]     key_q, key_d;
  result_t         res_q, res_d;
  logic            rv_q, rv_d;

  logic              we;
  logic [IdxW-1:0]   waddr, raddr;
  entry_t            wdata, rdata;
  logic [EntryW-1:0] rdata_raw;
  logic [CntW-1:0]   lim;
  logic              hit, m_user, m_caller, m_uri, out_free, retry;

  assign rdata = entry_t'(rdata_raw);

  ostab_ram #(.Width(EntryW), .Depth(TableDepth)) u_ram (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(EntryW'(wdata)),
    .raddr_i(raddr), .rdata_o(rdata_raw)
  );

  always_comb begin
    if (limit_i == 5'd0) lim = CntW'(1);
    else if (limit_i > 5'(TableDepth)) lim = CntW'(TableDepth);
    else lim = CntW'(limit_i);
  end

  assign m_user   = rdata.user == cmd_q.user;
  assign m_caller = m_user && rdata.uid == cmd_q.uid;
  assign m_uri    = rdata.uri == cmd_q.uri;

  always_comb begin
    hit = 1'b0;
    case (act_q)
      ActCreate: hit = rdata.evict && !hits_q;
      ActQuery:  hit = rdata.handle == cmd_q.handle && m_caller;
      ActDelete: hit = rdata.handle == cmd_q.handle && !hits_q;
      default: begin
        case (mode_q)
          ModeUser:   hit = m_user;
          ModeCaller: hit = m_caller;
          ModeUri:    hit = m_uri;
          default:    hit = m_caller && m_uri;
        endcase
      end
    endcase
  end

  assign out_free = !rv_q || res_ready_i;
  // a criteria hit with an earlier removal still to deliver and the output
  // register taken: drop the read and fetch the same entry again
  assign retry = rvld_q && hit && act_q == ActCriteria && hits_q && !out_free;
  assign raddr = rd_q[IdxW-1:0];

  always_comb begin
    state_d = state_q; total_d = total_q; rd_d = rd_q; wr_d = wr_q; rm_d = rm_q;
    cur_d = cur_q; rvld_d = 1'b0; hits_d = hits_q; full_d = full_q;
    slot_d = slot_q; key_d = key_q; res_d = res_q;
    rv_d = rv_q && !res_ready_i;
    we = 1'b0; waddr = wr_q[IdxW-1:0]; wdata = rdata;
    case (state_q)
      SIdle: begin
        if (start_i) begin
          rd_d = '0; wr_d = '0; rm_d = '0; hits_d = 1'b0; key_d = '0; slot_d = '0;
          full_d = total_q >= lim;
          // create below limit skips the scan
          if (action_i == ActCreate && total_q < lim) state_d = SEnd;
          else state_d = SScan;
        end
      end
      SScan: begin
        if (rd_q < total_q) begin
          rd_d = rd_q + CntW'(1); cur_d = rd_q[IdxW-1:0]; rvld_d = 1'b1;
        end
        if (rvld_q) begin
          if (retry) begin
            rd_d = CntW'(cur_q); rvld_d = 1'b0;
          end else if (hit) begin
            hits_d = 1'b1;
            if (act_q == ActQuery) begin
              slot_d = cur_q; state_d = SEnd;
            end else if (act_q == ActCreate) begin
              key_d = 64'(rdata.handle);
            end else if (act_q == ActCriteria) begin
              if (hits_q) begin
                res_d = '{StOk, 4'd0, 1'b1, key_q, 5'(total_q - rm_q), 1'b0};
                rv_d = 1'b1;
              end
              key_d = 64'(rdata.handle);
              rm_d = rm_q + CntW'(1);
            end
          end else begin
            we = 1'b1; wr_d = wr_q + CntW'(1);
          end
        end
        if (state_d == SScan && rd_q >= total_q && !retry) begin
          total_d = wr_d;
          state_d = SEnd;
        end
      end
      SEnd: begin
        if (out_free) begin
          rv_d = 1'b1; state_d = SIdle;
          case (act_q)
            ActCreate: begin
              if (full_q && !hits_q) begin
                res_d = '{StLimit, 4'd0, 1'b0, 64'd0, 5'(total_q), 1'b1};
              end else begin
                // append
                if (total_q < CntW'(TableDepth)) begin
                  we = 1'b1; waddr = total_q[IdxW-1:0]; wdata = cmd_q;
                  total_d = total_q + CntW'(1);
                end
                res_d = '{StOk, 4'd0, hits_q, key_q, 5'(total_d), 1'b1};
              end
            end
            ActQuery: begin
              if (hits_q) res_d = '{StOk, slot_q, 1'b0, 64'd0, 5'(total_q), 1'b1};
              else res_d = '{StNotFound, 4'd0, 1'b0, 64'd0, 5'(total_q), 1'b1};
            end
            ActDelete: begin
              if (hits_q) res_d = '{StOk, 4'd0, 1'b0, 64'd0, 5'(total_q), 1'b1};
              else res_d = '{StNotFound, 4'd0, 1'b0, 64'd0, 5'(total_q), 1'b1};
            end
            default: begin
              if (hits_q) res_d = '{StOk, 4'd0, 1'b1, key_q, 5'(total_q), 1'b1};
              else res_d = '{StNotFound, 4'd0, 1'b0, 64'd0, 5'(total_q), 1'b1};
            end
          endcase
        end
      end
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle; total_q <= '0; rd_q <= '0; wr_q <= '0; rm_q <= '0;
      cur_q <= '0; rvld_q <= 1'b0; hits_q <= 1'b0; full_q <= 1'b0;
      slot_q <= '0; key_q <= '0; res_q <= '0; rv_q <= 1'b0;
      act_q <= ActCreate; mode_q <= ModeUser;
    end else begin
      state_q <= state_d; total_q <= total_d; rd_q <= rd_d; wr_q <= wr_d;
      rm_q <= rm_d; cur_q <= cur_d; rvld_q <= rvld_d; hits_q <= hits_d;
      full_q <= full_d; slot_q <= slot_d; key_q <= key_d; res_q <= res_d;
      rv_q <= rv_d;
      if (state_q == SIdle && start_i) begin
        act_q <= action_i; mode_q <= mode_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == SIdle && start_i) cmd_q <= cmd_i;
  end

  assign busy_o      = (state_q != SIdle) || rv_q;
  assign res_valid_o = rv_q;
  assign res_o       = res_q;

  `OST_ASSERT(a_cnt_range, total_q <= CntW'(TableDepth), "count over depth")
  `OST_ASSERT(a_wr_le_rd, wr_q <= rd_q, "compaction overran")
  `OST_ASSERT(a_idle_start, start_i |-> state_q == SIdle && !rv_q, "start while busy")
  `OST_ASSERT(a_res_hold, rv_q && !res_ready_i |=> rv_q && $stable(res_q), "result lost")
endmodule
`default_nettype wire

[hdl/ordered_session_table_with_eviction_unit.sv]
// ----------------------------------------------------------------------------
// ordered_session_table_with_eviction_unit
// insertion-ordered session table with eviction of the oldest abortable entry
// ----------------------------------------------------------------------------
// Commands arrive on the s_axis stream (one transfer per command) and results
// leave on m_axis; a criteria delete gives one transfer per removed session,
// the final one marked by m_axis_tlast. Entries live in one synchronous ram;
// a scanning command reads the n live entries one per cycle, except when a
// criteria hit meets a full result register, compacting in place as removals
// happen; a query stops at its hit. Further criteria results are sent during
// the scan and hold it up only while m_axis_tready is low. One command is
// worked at a time; s_axis_tready returns the cycle after the final result
// transfer. cfg_we_i writes the session limit (reset value 15); the user must
// write it only while idle, which the block itself does not enforce. Reset
// clears the live count; ram contents need no clearing. When m_axis_tready is
// low the result register holds; a criteria hit that meets a full result
// register re-reads its entry.
`default_nettype none
module ordered_session_table_with_eviction_unit
  import ostab_pkg::*;
(
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         cfg_we_i,
  input  wire logic [4:0]   cfg_wdata_i,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  // handle_key[63:0], user_id[95:64], caller_uid[127:96], uri_tag[191:128]
  input  wire logic [191:0] s_axis_tdata,
  // action[1:0], may_abort[2], match_mode[4:3]
  input  wire logic [4:0]   s_axis_tuser,
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // found_slot[3:0], abort_request[4], abort_key[68:5], live_count[73:69]
  output logic [79:0]       m_axis_tdata,
  // status[1:0]
  output logic [1:0]        m_axis_tuser,
  output logic              m_axis_tlast
);
  logic [4:0] limit_q;
  logic       busy;
  entry_t     cmd;
  result_t    res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) limit_q <= 5'd15;
    else if (cfg_we_i) limit_q <= cfg_wdata_i;
  end

  assign cmd = '{s_axis_tdata[KeyWidth-1:0], s_axis_tdata[95:64],
                 s_axis_tdata[127:96], s_axis_tdata[128+KeyWidth-1:128],
                 s_axis_tuser[2]};
  assign s_axis_tready = !busy;

  ostab_ctrl u_ctrl (
    .clk_i, .rst_ni, .limit_i(limit_q),
    .start_i(s_axis_tvalid && s_axis_tready), .action_i(s_axis_tuser[1:0]),
    .cmd_i(cmd), .mode_i(s_axis_tuser[4:3]), .busy_o(busy),
    .res_valid_o(m_axis_tvalid), .res_ready_i(m_axis_tready), .res_o(res)
  );

  assign m_axis_tdata = {6'd0, res.live_count, res.abort_key,
                         res.abort_request, res.found_slot};
  assign m_axis_tuser = res.status;
  assign m_axis_tlast = res.last;
endmodule
`default_nettype wire
